// ===== rtl/core/ip_fragment_hole_tracker_assert.svh =====
// Assertion macros shared by the hole tracker RTL.
// Depends on nothing; define ASSERT_OFF to compile the checks away.
`ifndef IP_FRAGMENT_HOLE_TRACKER_ASSERT_SVH
`define IP_FRAGMENT_HOLE_TRACKER_ASSERT_SVH
`ifndef ASSERT_OFF
`define IPFH_ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define IPFH_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define IPFH_ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define IPFH_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

// ===== rtl/core/ipfh_pkg.sv =====
// Shared types and constants of the IPv4 fragment hole tracker.
// Depends on nothing; used by ipfh_hole_alu and the top level.
`default_nettype none
package ipfh_pkg;

    localparam int DATA_W        = 16;
    localparam int HOLE_W        = 2 * DATA_W;
    localparam int CFG_W         = 17;
    localparam int HOLES_OUT_W   = 4;
    localparam int MAX_HOLES_DEF = 8;

    localparam logic [DATA_W-1:0] HOLE_INF     = 16'hFFFF;
    localparam logic [CFG_W-1:0]  BUF_SIZE_RST = 17'h10000;

    localparam logic CMD_CLEAR = 1'b0;
    localparam logic CMD_FRAG  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROC,
        ST_RIGHT,
        ST_FIN
    } state_t;

    // Outcome of comparing one hole against the current fragment.
    typedef struct packed {
        logic              hit;
        logic              left;
        logic              right;
        logic [DATA_W-1:0] left_end;
        logic [DATA_W-1:0] right_start;
    } hole_calc_t;

endpackage
`default_nettype wire

// ===== rtl/core/ipfh_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
`default_nettype none
module ipfh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== rtl/core/ipfh_hole_alu.sv =====
// Shared compare and adjust unit: checks one hole against the fragment.
// Depends on ipfh_pkg.
`default_nettype none
module ipfh_hole_alu (
    input  wire logic [ipfh_pkg::DATA_W-1:0] hole_start,
    input  wire logic [ipfh_pkg::DATA_W-1:0] hole_end,
    input  wire logic [ipfh_pkg::DATA_W-1:0] frag_first,
    input  wire logic [ipfh_pkg::DATA_W-1:0] frag_last,
    input  wire logic                        more_frags,
    output ipfh_pkg::hole_calc_t             calc
);
    import ipfh_pkg::*;

    always_comb begin
        // The fragment touches the hole unless it lies wholly on one side.
        calc.hit         = !((frag_first > hole_end) || (frag_last < hole_start));
        calc.left        = frag_first > hole_start;
        calc.right       = (frag_last < hole_end) && more_frags;
        calc.left_end    = frag_first - DATA_W'(1);
        calc.right_start = frag_last + DATA_W'(1);
    end

endmodule
`default_nettype wire

// ===== rtl/core/ip_fragment_hole_tracker.sv =====
// Top level of the IPv4 fragment hole tracker (RFC 815 hole list).
// Depends on ipfh_pkg, ipfh_ram, ipfh_hole_alu and the assertion macro header.
`default_nettype none
`include "ip_fragment_hole_tracker_assert.svh"
// The tracker keeps the list of byte ranges (holes) still missing from one
// IPv4 datagram. A clear transfer (cmd 0) starts a datagram with the single
// hole 0..infinity, where an end of 65535 stands for infinity. A fragment
// transfer (cmd 1) gives an inclusive byte range and the more-fragments flag;
// every hole it touches is replaced by the part left of the fragment and,
// when more fragments follow, the part right of it. Each input transfer
// yields exactly one result transfer with the filled, too_large, table_full
// and complete flags and the hole count (low four bits). A fragment whose
// last byte is below its first byte is ignored. New holes beyond MAX_HOLES
// slots are dropped and flagged by table_full.
//
// Timing: the hole list lives in a RAM split into two banks; a fragment is
// walked through the live bank one hole per cycle by a single compare unit,
// except where a split hole holds the walk, and the rebuilt list is written
// to the other bank, which becomes live at the end. The single write port
// takes one new hole per cycle, so the right part of a hole split on both
// sides is written in a separate ST_RIGHT state before the walk moves on.
// The input is not ready while an item is in work. The result sits in an
// output register, so the next item is accepted while a result still waits;
// the block only stalls when a second result is finished before the first
// was taken. After reset the hole list holds one slot whose bounds are
// undefined, so a clear should come first. buffer_size may only be written
// while no item is in work.
module ip_fragment_hole_tracker #(
    parameter int MAX_HOLES = ipfh_pkg::MAX_HOLES_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Configuration: buffer_size register.
    input  wire logic                             cfg_wr_en,
    input  wire logic [ipfh_pkg::CFG_W-1:0]       cfg_wr_data,
    // Input channel.
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_cmd,
    input  wire logic [ipfh_pkg::DATA_W-1:0]      s_frag_first,
    input  wire logic [ipfh_pkg::DATA_W-1:0]      s_frag_last,
    input  wire logic                             s_more_frags,
    // Result channel.
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic                                  m_filled,
    output logic                                  m_too_large,
    output logic                                  m_table_full,
    output logic                                  m_complete,
    output logic [ipfh_pkg::HOLES_OUT_W-1:0]      m_holes_left
);
    import ipfh_pkg::*;

    // Hole counts range over 0..MAX_HOLES; slot indexes over 0..MAX_HOLES-1.
    localparam int CNT_W     = $clog2(MAX_HOLES + 1);
    localparam int IDX_W     = $clog2(MAX_HOLES);
    localparam int RAM_AW    = IDX_W + 1;
    localparam int RAM_DEPTH = 2 * (2 ** IDX_W);

    // Sequencer and walk state.
    state_t             state_reg, state_next;
    logic               bank_reg, bank_next;
    logic [CNT_W-1:0]   total_reg, total_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               commit_reg, commit_next;
    logic               filled_reg, filled_next;
    logic               dropped_reg, dropped_next;
    logic [DATA_W-1:0]  ff_reg, ff_next;
    logic [DATA_W-1:0]  fl_reg, fl_next;
    logic               more_reg, more_next;
    logic [CFG_W-1:0]   buf_size_reg;

    // Result register.
    logic                   m_valid_reg;
    logic                   m_filled_reg;
    logic                   m_too_large_reg;
    logic                   m_table_full_reg;
    logic                   m_complete_reg;
    logic [HOLES_OUT_W-1:0] m_holes_left_reg;
    logic                   out_load;
    logic [CNT_W-1:0]       out_total;
    logic [CNT_W+HOLES_OUT_W-1:0] out_total_ext;

    // Hole RAM ports.
    logic               ram_we;
    logic [RAM_AW-1:0]  ram_waddr;
    logic [HOLE_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [RAM_AW-1:0]  ram_raddr;
    logic [HOLE_W-1:0]  ram_rdata;

    // Append lane: at most one new hole per cycle.
    logic               app_en;
    logic [DATA_W-1:0]  app_start;
    logic [DATA_W-1:0]  app_end;

    logic [CNT_W-1:0]   idx_inc;
    logic [DATA_W-1:0]  rd_start;
    logic [DATA_W-1:0]  rd_end;
    hole_calc_t         calc;

    assign rd_start = ram_rdata[HOLE_W-1:DATA_W];
    assign rd_end   = ram_rdata[DATA_W-1:0];
    assign idx_inc  = idx_reg + CNT_W'(1);

    ipfh_ram #(
        .WIDTH (HOLE_W),
        .DEPTH (RAM_DEPTH)
    ) u_hole_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ipfh_hole_alu u_hole_alu (
        .hole_start (rd_start),
        .hole_end   (rd_end),
        .frag_first (ff_reg),
        .frag_last  (fl_reg),
        .more_frags (more_reg),
        .calc       (calc)
    );

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        bank_next    = bank_reg;
        total_next   = total_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        commit_next  = commit_reg;
        filled_next  = filled_reg;
        dropped_next = dropped_reg;
        ff_next      = ff_reg;
        fl_next      = fl_reg;
        more_next    = more_reg;
        ram_we       = 1'b0;
        ram_waddr    = {~bank_reg, cnt_reg[IDX_W-1:0]};
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = {bank_reg, idx_reg[IDX_W-1:0]};
        app_en       = 1'b0;
        app_start    = rd_start;
        app_end      = rd_end;
        out_load     = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ff_next      = s_frag_first;
                    fl_next      = s_frag_last;
                    more_next    = s_more_frags;
                    filled_next  = 1'b0;
                    dropped_next = 1'b0;
                    idx_next     = '0;
                    cnt_next     = '0;
                    if (s_cmd == CMD_CLEAR) begin
                        // New datagram: one hole 0..infinity in the spare bank.
                        ram_we      = 1'b1;
                        ram_waddr   = {~bank_reg, IDX_W'(0)};
                        ram_wdata   = {DATA_W'(0), HOLE_INF};
                        cnt_next    = CNT_W'(1);
                        commit_next = 1'b1;
                        state_next  = ST_FIN;
                    end else if (s_frag_last < s_frag_first) begin
                        commit_next = 1'b0;
                        state_next  = ST_FIN;
                    end else begin
                        commit_next = 1'b1;
                        if (total_reg != '0) begin
                            ram_re     = 1'b1;
                            ram_raddr  = {bank_reg, IDX_W'(0)};
                            state_next = ST_PROC;
                        end else begin
                            state_next = ST_FIN;
                        end
                    end
                end
            end

            ST_PROC: begin
                idx_next = idx_inc;
                if (!calc.hit) begin
                    app_en = 1'b1;
                end else begin
                    filled_next = 1'b1;
                    if (calc.left) begin
                        app_en  = 1'b1;
                        app_end = calc.left_end;
                    end else if (calc.right) begin
                        app_en    = 1'b1;
                        app_start = calc.right_start;
                    end
                end
                if (calc.hit && calc.left && calc.right) begin
                    // Right part goes next cycle; read data must hold meanwhile.
                    state_next = ST_RIGHT;
                end else if (idx_inc < total_reg) begin
                    ram_re     = 1'b1;
                    ram_raddr  = {bank_reg, idx_inc[IDX_W-1:0]};
                    state_next = ST_PROC;
                end else begin
                    state_next = ST_FIN;
                end
            end

            ST_RIGHT: begin
                app_en    = 1'b1;
                app_start = calc.right_start;
                if (idx_reg < total_reg) begin
                    ram_re     = 1'b1;
                    state_next = ST_PROC;
                end else begin
                    state_next = ST_FIN;
                end
            end

            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                    if (commit_reg) begin
                        bank_next  = ~bank_reg;
                        total_next = cnt_reg;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (app_en) begin
            if (cnt_reg < CNT_W'(MAX_HOLES)) begin
                ram_we    = 1'b1;
                ram_waddr = {~bank_reg, cnt_reg[IDX_W-1:0]};
                ram_wdata = {app_start, app_end};
                cnt_next  = cnt_reg + CNT_W'(1);
            end else begin
                dropped_next = 1'b1;
            end
        end
    end

    assign out_total     = commit_reg ? cnt_reg : total_reg;
    assign out_total_ext = {{HOLES_OUT_W{1'b0}}, out_total};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            bank_reg     <= 1'b0;
            total_reg    <= CNT_W'(1);
            idx_reg      <= '0;
            cnt_reg      <= '0;
            commit_reg   <= 1'b0;
            filled_reg   <= 1'b0;
            dropped_reg  <= 1'b0;
            buf_size_reg <= BUF_SIZE_RST;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            bank_reg    <= bank_next;
            total_reg   <= total_next;
            idx_reg     <= idx_next;
            cnt_reg     <= cnt_next;
            commit_reg  <= commit_next;
            filled_reg  <= filled_next;
            dropped_reg <= dropped_next;
            if (cfg_wr_en) begin
                buf_size_reg <= cfg_wr_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Fragment bounds and result payload carry no reset.
    always_ff @(posedge aclk) begin
        ff_reg   <= ff_next;
        fl_reg   <= fl_next;
        more_reg <= more_next;
        if (out_load) begin
            m_filled_reg     <= filled_reg;
            m_too_large_reg  <= filled_reg && ({1'b0, fl_reg} >= buf_size_reg);
            m_table_full_reg <= dropped_reg;
            m_complete_reg   <= (out_total == '0);
            m_holes_left_reg <= out_total_ext[HOLES_OUT_W-1:0];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_filled     = m_filled_reg;
    assign m_too_large  = m_too_large_reg;
    assign m_table_full = m_table_full_reg;
    assign m_complete   = m_complete_reg;
    assign m_holes_left = m_holes_left_reg;

    // The rebuilt list must never be written into the bank being walked.
    `IPFH_ASSERT_NEVER(a_write_live_bank, aclk, aresetn,
        ram_we && (ram_waddr[RAM_AW-1] == bank_reg), "hole write hit the live bank")
    `IPFH_ASSERT_PROP(a_cnt_bound, aclk, aresetn,
        (cnt_reg <= CNT_W'(MAX_HOLES)), "new hole count exceeds table size")
    `IPFH_ASSERT_PROP(a_walk_bound, aclk, aresetn,
        (state_reg == ST_PROC) |-> (idx_reg < total_reg), "walk ran past the hole list")
    `IPFH_ASSERT_PROP(a_complete_match, aclk, aresetn,
        $rose(m_valid_reg) |-> (m_complete_reg == (total_reg == '0)),
        "complete flag disagrees with committed hole count")
    `IPFH_ASSERT_NEVER(a_too_large_unfilled, aclk, aresetn,
        m_valid_reg && m_too_large_reg && !m_filled_reg, "too_large without filled")

endmodule
`default_nettype wire
